### src/sfla_pkg.sv
// Package for the segregated free-list allocator.
// Holds heap constants, result codes, transfer and header word types, and the size-class map.
// No dependencies.
`timescale 1ns / 1ps
package sfla_pkg;

  localparam int HEAP_BYTES   = 16384;
  localparam int CLASS_COUNT  = 8;
  localparam int HEADER_BYTES = 16;
  localparam int GRANULES     = HEAP_BYTES / 8;
  localparam int GW           = $clog2(GRANULES);
  localparam int LW           = GW + 1;
  localparam int CW           = $clog2(CLASS_COUNT);
  localparam int SIZE_W       = 15;
  localparam int REQ_W        = 17;

  localparam logic [LW-1:0] NIL = {LW{1'b1}};

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ZERO      = 3'd1;
  localparam logic [2:0] ST_OOM       = 3'd2;
  localparam logic [2:0] ST_BAD_PTR   = 3'd3;
  localparam logic [2:0] ST_NOT_ALLOC = 3'd4;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef struct packed {
    logic        command;
    logic [15:0] request_bytes;
    logic [13:0] free_offset;
  } in_t;

  typedef struct packed {
    logic [2:0]  result_status;
    logic [13:0] payload_offset;
    logic [13:0] granted_bytes;
    logic        residual_split;
    logic [1:0]  merge_count;
    logic [10:0] live_blocks;
    logic [14:0] used_bytes;
  } out_t;

  typedef struct packed {
    logic              mark;
    logic              status;
    logic [SIZE_W-1:0] size;
    logic [LW-1:0]     hprev;
    logic [LW-1:0]     fnext;
    logic [LW-1:0]     fprev;
  } hdr_t;

  localparam int HDR_W = $bits(hdr_t);

  function automatic logic [CW-1:0] class_of(input logic [REQ_W-1:0] sz);
    logic [CW-1:0] c;
    if (sz <= REQ_W'(8))        c = CW'(0);
    else if (sz <= REQ_W'(16))  c = CW'(1);
    else if (sz <= REQ_W'(32))  c = CW'(2);
    else if (sz <= REQ_W'(64))  c = CW'(3);
    else if (sz <= REQ_W'(128)) c = CW'(4);
    else if (sz <= REQ_W'(256)) c = CW'(5);
    else if (sz <= REQ_W'(512)) c = CW'(6);
    else                        c = CW'(7);
    return c;
  endfunction

endpackage

### src/segregated_free_list_allocator.sv
// Top level of the segregated free-list allocator: sequencer, class heads, counters.
// Depends on sfla_pkg and sfla_ram (one header word per granule).
//
//  channel | ports                        | dir | payload
//  in      | in_valid, in_stall, in_data  | in  | in_t  (command, request, offset)
//  out     | out_valid, out_stall, out_data | out | out_t (status and counters)
//
// One request at a time; each header access is a read then a write on the single RAM port.
// Allocate walks the free list of the request's class, falls back to the lowest non-empty larger
// class, and may split off a remainder. Free merges with free neighbours on either side.
// A zero-size request or a bad free is rejected early; the sequencer then returns to idle.
// After reset a clearing pass over all 2048 header words initialises the header RAM; in_stall is high.
// A finished result sits in the output register; the sequencer waits only if it is still held.
`timescale 1ns / 1ps
module segregated_free_list_allocator
  import sfla_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam logic [5:0] S_CLR   = 6'd0;
  localparam logic [5:0] S_IDLE  = 6'd1;
  localparam logic [5:0] S_AL0   = 6'd2;
  localparam logic [5:0] S_AWALK = 6'd3;
  localparam logic [5:0] S_ACHK  = 6'd4;
  localparam logic [5:0] S_AHIGH = 6'd5;
  localparam logic [5:0] S_AS0   = 6'd6;
  localparam logic [5:0] S_AS1   = 6'd7;
  localparam logic [5:0] S_AS2   = 6'd8;
  localparam logic [5:0] S_AS3   = 6'd9;
  localparam logic [5:0] S_AFIN  = 6'd10;
  localparam logic [5:0] S_FR0   = 6'd11;
  localparam logic [5:0] S_FR1   = 6'd12;
  localparam logic [5:0] S_FR2   = 6'd13;
  localparam logic [5:0] S_FR3   = 6'd14;
  localparam logic [5:0] S_FR4   = 6'd15;
  localparam logic [5:0] S_FR4B  = 6'd16;
  localparam logic [5:0] S_FR4C  = 6'd17;
  localparam logic [5:0] S_FR4D  = 6'd18;
  localparam logic [5:0] S_FR5   = 6'd19;
  localparam logic [5:0] S_FR6   = 6'd20;
  localparam logic [5:0] S_FR7   = 6'd21;
  localparam logic [5:0] S_FR8   = 6'd22;
  localparam logic [5:0] S_FR9   = 6'd23;
  localparam logic [5:0] S_FR10  = 6'd24;
  localparam logic [5:0] S_FR11  = 6'd25;
  localparam logic [5:0] S_FR12  = 6'd26;
  localparam logic [5:0] S_FPUSH = 6'd27;
  localparam logic [5:0] S_FFIN  = 6'd28;
  localparam logic [5:0] S_DONE  = 6'd29;
  localparam logic [5:0] S_UL0   = 6'd30;
  localparam logic [5:0] S_UL1   = 6'd31;
  localparam logic [5:0] S_UL2   = 6'd32;
  localparam logic [5:0] S_UL3   = 6'd33;
  localparam logic [5:0] S_UL4   = 6'd34;
  localparam logic [5:0] S_PU0   = 6'd35;
  localparam logic [5:0] S_PU1   = 6'd36;
  localparam logic [5:0] S_PU2   = 6'd37;
  localparam logic [5:0] S_PU3   = 6'd38;
  localparam logic [5:0] S_RL0   = 6'd39;
  localparam logic [5:0] S_RL1   = 6'd40;
  localparam logic [5:0] S_RL2   = 6'd41;

  logic [5:0]        st_r, st_nxt, ret_r, ret_nxt;
  in_t               cmd_r, cmd_nxt;
  logic [REQ_W-1:0]  sz_r, sz_nxt;
  logic [CW-1:0]     cls_r, cls_nxt;
  logic [LW-1:0]     b_r, b_nxt, p_r, p_nxt, n_r, n_nxt, h_r, h_nxt;
  logic [LW-1:0]     ulp_r, ulp_nxt, uln_r, uln_nxt;
  logic [GW-1:0]     g_r, g_nxt, x_r, x_nxt, r_r, r_nxt, a_r, a_nxt;
  logic [SIZE_W-1:0] tsz_r, tsz_nxt;
  logic [13:0]       granted_r, granted_nxt;
  logic              split_r, split_nxt;
  logic [1:0]        merges_r, merges_nxt;
  logic [2:0]        status_r, status_nxt;
  logic [10:0]       count_r, count_nxt;
  logic [14:0]       used_r, used_nxt;
  logic [LW-1:0]     heads_r [CLASS_COUNT];
  logic [LW-1:0]     heads_nxt [CLASS_COUNT];
  logic [GW-1:0]     clr_r, clr_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_r, out_nxt;

  logic              ram_we;
  logic [GW-1:0]     ram_addr;
  hdr_t              ram_wdata, rd;

  logic [REQ_W-1:0]  rounded;
  logic [CW-1:0]     cls_req;
  logic              hi_found;
  logic [LW-1:0]     hi_head;
  logic [GW+1:0]     fol;
  logic [13:0]       off_m;
  logic [CW-1:0]     rd_cls;

  sfla_ram #(.WIDTH(HDR_W), .DEPTH(GRANULES)) u_hdr_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (rd)
  );

  assign in_stall  = (st_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign rounded = ({1'b0, cmd_r.request_bytes} + REQ_W'(7)) & ~REQ_W'(7);
  assign cls_req = class_of(rounded);
  assign rd_cls  = class_of(REQ_W'(rd.size));
  assign fol     = (GW+2)'(x_r) + (GW+2)'((REQ_W'(HEADER_BYTES) + REQ_W'(rd.size)) >> 3);
  assign off_m   = cmd_r.free_offset - 14'(HEADER_BYTES);

  always_comb begin
    hi_found = 1'b0;
    hi_head  = NIL;
    for (int k = 0; k < CLASS_COUNT; k++) begin
      if (!hi_found && (CW'(k) > cls_r) && !heads_r[k][LW-1]) begin
        hi_found = 1'b1;
        hi_head  = heads_r[k];
      end
    end
  end

  always_comb begin
    st_nxt        = st_r;
    ret_nxt       = ret_r;
    cmd_nxt       = cmd_r;
    sz_nxt        = sz_r;
    cls_nxt       = cls_r;
    b_nxt         = b_r;
    p_nxt         = p_r;
    n_nxt         = n_r;
    h_nxt         = h_r;
    ulp_nxt       = ulp_r;
    uln_nxt       = uln_r;
    g_nxt         = g_r;
    x_nxt         = x_r;
    r_nxt         = r_r;
    a_nxt         = a_r;
    tsz_nxt       = tsz_r;
    granted_nxt   = granted_r;
    split_nxt     = split_r;
    merges_nxt    = merges_r;
    status_nxt    = status_r;
    count_nxt     = count_r;
    used_nxt      = used_r;
    clr_nxt       = clr_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    for (int k = 0; k < CLASS_COUNT; k++) begin
      heads_nxt[k] = heads_r[k];
    end
    ram_we    = 1'b0;
    ram_addr  = '0;
    ram_wdata = rd;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (st_r)
      S_CLR: begin
        ram_we   = 1'b1;
        ram_addr = clr_r;
        if (clr_r == '0) begin
          ram_wdata = '{mark: 1'b1, status: 1'b0,
                        size: SIZE_W'(HEAP_BYTES - HEADER_BYTES),
                        hprev: NIL, fnext: NIL, fprev: NIL};
        end else begin
          ram_wdata = '0;
        end
        clr_nxt = clr_r + GW'(1);
        if (clr_r == GW'(GRANULES - 1)) begin
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt     = in_data;
          granted_nxt = '0;
          split_nxt   = 1'b0;
          merges_nxt  = '0;
          st_nxt      = (in_data.command == CMD_ALLOC) ? S_AL0 : S_FR0;
        end
      end
      S_AL0: begin
        if (cmd_r.request_bytes == '0) begin
          status_nxt = ST_ZERO;
          st_nxt     = S_DONE;
        end else begin
          sz_nxt  = rounded;
          cls_nxt = cls_req;
          b_nxt   = heads_r[cls_req];
          st_nxt  = S_AWALK;
        end
      end
      S_AWALK: begin
        if (b_r[LW-1]) begin
          st_nxt = S_AHIGH;
        end else begin
          ram_addr = b_r[GW-1:0];
          st_nxt   = S_ACHK;
        end
      end
      S_ACHK: begin
        if (REQ_W'(rd.size) >= sz_r) begin
          g_nxt   = b_r[GW-1:0];
          x_nxt   = b_r[GW-1:0];
          ret_nxt = S_AS0;
          st_nxt  = S_UL0;
        end else begin
          b_nxt  = rd.fnext;
          st_nxt = S_AWALK;
        end
      end
      S_AHIGH: begin
        if (hi_found) begin
          g_nxt   = hi_head[GW-1:0];
          x_nxt   = hi_head[GW-1:0];
          ret_nxt = S_AS0;
          st_nxt  = S_UL0;
        end else begin
          status_nxt = ST_OOM;
          st_nxt     = S_DONE;
        end
      end
      S_AS0: begin
        ram_addr = g_r;
        st_nxt   = S_AS1;
      end
      S_AS1: begin
        ram_we           = 1'b1;
        ram_addr         = g_r;
        ram_wdata.status = 1'b1;
        if ((REQ_W+1)'(rd.size) >= (REQ_W+1)'(sz_r) + (REQ_W+1)'(HEADER_BYTES + 8)) begin
          ram_wdata.size = sz_r[SIZE_W-1:0];
          r_nxt          = g_r + GW'((sz_r + REQ_W'(HEADER_BYTES)) >> 3);
          tsz_nxt        = rd.size - sz_r[SIZE_W-1:0] - SIZE_W'(HEADER_BYTES);
          granted_nxt    = sz_r[13:0];
          split_nxt      = 1'b1;
          st_nxt         = S_AS2;
        end else begin
          granted_nxt = rd.size[13:0];
          st_nxt      = S_AFIN;
        end
      end
      S_AS2: begin
        ram_we    = 1'b1;
        ram_addr  = r_r;
        ram_wdata = '{mark: 1'b1, status: 1'b0, size: tsz_r,
                      hprev: {1'b0, g_r}, fnext: NIL, fprev: NIL};
        x_nxt     = r_r;
        ret_nxt   = S_AS3;
        st_nxt    = S_RL0;
      end
      S_AS3: begin
        x_nxt   = r_r;
        ret_nxt = S_AFIN;
        st_nxt  = S_PU0;
      end
      S_AFIN: begin
        count_nxt  = count_r + 11'd1;
        used_nxt   = used_r + 15'(granted_r) + 15'(HEADER_BYTES);
        status_nxt = ST_OK;
        st_nxt     = S_DONE;
      end
      S_FR0: begin
        if (cmd_r.free_offset < 14'(HEADER_BYTES) || cmd_r.free_offset[2:0] != 3'd0) begin
          status_nxt = ST_BAD_PTR;
          st_nxt     = S_DONE;
        end else begin
          g_nxt    = GW'(off_m >> 3);
          ram_addr = GW'(off_m >> 3);
          st_nxt   = S_FR1;
        end
      end
      S_FR1: begin
        if (!rd.mark) begin
          status_nxt = ST_BAD_PTR;
          st_nxt     = S_DONE;
        end else if (!rd.status) begin
          status_nxt = ST_NOT_ALLOC;
          st_nxt     = S_DONE;
        end else begin
          ram_we           = 1'b1;
          ram_addr         = g_r;
          ram_wdata.status = 1'b0;
          count_nxt        = count_r - 11'd1;
          used_nxt         = used_r - rd.size - 15'(HEADER_BYTES);
          x_nxt            = g_r;
          st_nxt           = S_FR2;
        end
      end
      S_FR2: begin
        ram_addr = g_r;
        st_nxt   = S_FR3;
      end
      S_FR3: begin
        if (fol < (GW+2)'(GRANULES)) begin
          n_nxt    = LW'(fol);
          ram_addr = fol[GW-1:0];
          st_nxt   = S_FR4;
        end else begin
          st_nxt = S_FR5;
        end
      end
      S_FR4: begin
        if (rd.mark && !rd.status) begin
          tsz_nxt    = rd.size;
          x_nxt      = n_r[GW-1:0];
          merges_nxt = 2'd1;
          ret_nxt    = S_FR4B;
          st_nxt     = S_UL0;
        end else begin
          st_nxt = S_FR5;
        end
      end
      S_FR4B: begin
        ram_addr = g_r;
        st_nxt   = S_FR4C;
      end
      S_FR4C: begin
        ram_we         = 1'b1;
        ram_addr       = g_r;
        ram_wdata.size = rd.size + tsz_r + SIZE_W'(HEADER_BYTES);
        st_nxt         = S_FR4D;
      end
      S_FR4D: begin
        ram_addr = n_r[GW-1:0];
        st_nxt   = S_FR12;
        ret_nxt  = S_FR5;
      end
      S_FR5: begin
        ram_addr = g_r;
        st_nxt   = S_FR6;
      end
      S_FR6: begin
        p_nxt = rd.hprev;
        if (!rd.hprev[LW-1]) begin
          ram_addr = rd.hprev[GW-1:0];
          st_nxt   = S_FR7;
        end else begin
          st_nxt = S_FPUSH;
        end
      end
      S_FR7: begin
        if (rd.mark && !rd.status) begin
          x_nxt   = p_r[GW-1:0];
          ret_nxt = S_FR8;
          st_nxt  = S_UL0;
        end else begin
          st_nxt = S_FPUSH;
        end
      end
      S_FR8: begin
        ram_addr = g_r;
        st_nxt   = S_FR9;
      end
      S_FR9: begin
        ram_we         = 1'b1;
        ram_addr       = g_r;
        ram_wdata.mark = 1'b0;
        tsz_nxt        = rd.size;
        st_nxt         = S_FR10;
      end
      S_FR10: begin
        ram_addr = p_r[GW-1:0];
        st_nxt   = S_FR11;
      end
      S_FR11: begin
        ram_we         = 1'b1;
        ram_addr       = p_r[GW-1:0];
        ram_wdata.size = rd.size + tsz_r + SIZE_W'(HEADER_BYTES);
        g_nxt          = p_r[GW-1:0];
        x_nxt          = p_r[GW-1:0];
        merges_nxt     = merges_r + 2'd1;
        ret_nxt        = S_FPUSH;
        st_nxt         = S_RL0;
      end
      S_FR12: begin
        // clear the absorbed header mark, then fix the follower's back link
        ram_we         = 1'b1;
        ram_addr       = n_r[GW-1:0];
        ram_wdata.mark = 1'b0;
        x_nxt          = g_r;
        st_nxt         = S_RL0;
      end
      S_FPUSH: begin
        x_nxt   = g_r;
        ret_nxt = S_FFIN;
        st_nxt  = S_PU0;
      end
      S_FFIN: begin
        status_nxt = ST_OK;
        st_nxt     = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.result_status  = status_r;
          out_nxt.payload_offset = '0;
          out_nxt.granted_bytes  = '0;
          out_nxt.residual_split = 1'b0;
          out_nxt.merge_count    = '0;
          if (status_r == ST_OK) begin
            if (cmd_r.command == CMD_ALLOC) begin
              out_nxt.payload_offset = 14'({g_r, 3'b000}) + 14'(HEADER_BYTES);
              out_nxt.granted_bytes  = granted_r;
              out_nxt.residual_split = split_r;
            end else begin
              out_nxt.merge_count = merges_r;
            end
          end
          out_nxt.live_blocks = count_r;
          out_nxt.used_bytes  = used_r;
          out_valid_nxt       = 1'b1;
          st_nxt              = S_IDLE;
        end
      end
      S_UL0: begin
        ram_addr = x_r;
        st_nxt   = S_UL1;
      end
      S_UL1: begin
        ulp_nxt = rd.fprev;
        uln_nxt = rd.fnext;
        if (!rd.fprev[LW-1]) begin
          ram_addr = rd.fprev[GW-1:0];
          st_nxt   = S_UL2;
        end else begin
          heads_nxt[rd_cls] = rd.fnext;
          st_nxt            = S_UL3;
        end
      end
      S_UL2: begin
        ram_we          = 1'b1;
        ram_addr        = ulp_r[GW-1:0];
        ram_wdata.fnext = uln_r;
        st_nxt          = S_UL3;
      end
      S_UL3: begin
        if (!uln_r[LW-1]) begin
          ram_addr = uln_r[GW-1:0];
          st_nxt   = S_UL4;
        end else begin
          st_nxt = ret_r;
        end
      end
      S_UL4: begin
        ram_we          = 1'b1;
        ram_addr        = uln_r[GW-1:0];
        ram_wdata.fprev = ulp_r;
        st_nxt          = ret_r;
      end
      S_PU0: begin
        ram_addr = x_r;
        st_nxt   = S_PU1;
      end
      S_PU1: begin
        ram_we            = 1'b1;
        ram_addr          = x_r;
        ram_wdata.fprev   = NIL;
        ram_wdata.fnext   = heads_r[rd_cls];
        h_nxt             = heads_r[rd_cls];
        heads_nxt[rd_cls] = {1'b0, x_r};
        st_nxt            = S_PU2;
      end
      S_PU2: begin
        if (!h_r[LW-1]) begin
          ram_addr = h_r[GW-1:0];
          st_nxt   = S_PU3;
        end else begin
          st_nxt = ret_r;
        end
      end
      S_PU3: begin
        ram_we          = 1'b1;
        ram_addr        = h_r[GW-1:0];
        ram_wdata.fprev = {1'b0, x_r};
        st_nxt          = ret_r;
      end
      S_RL0: begin
        ram_addr = x_r;
        st_nxt   = S_RL1;
      end
      S_RL1: begin
        if (fol < (GW+2)'(GRANULES)) begin
          a_nxt    = fol[GW-1:0];
          ram_addr = fol[GW-1:0];
          st_nxt   = S_RL2;
        end else begin
          st_nxt = ret_r;
        end
      end
      S_RL2: begin
        if (rd.mark) begin
          ram_we          = 1'b1;
          ram_addr        = a_r;
          ram_wdata.hprev = {1'b0, x_r};
        end
        st_nxt = ret_r;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLR;
      ret_r       <= S_IDLE;
      clr_r       <= '0;
      count_r     <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < CLASS_COUNT; k++) begin
        heads_r[k] <= (k == CLASS_COUNT - 1) ? LW'(0) : NIL;
      end
    end else begin
      st_r        <= st_nxt;
      ret_r       <= ret_nxt;
      clr_r       <= clr_nxt;
      count_r     <= count_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      for (int k = 0; k < CLASS_COUNT; k++) begin
        heads_r[k] <= heads_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    sz_r      <= sz_nxt;
    cls_r     <= cls_nxt;
    b_r       <= b_nxt;
    p_r       <= p_nxt;
    n_r       <= n_nxt;
    h_r       <= h_nxt;
    ulp_r     <= ulp_nxt;
    uln_r     <= uln_nxt;
    g_r       <= g_nxt;
    x_r       <= x_nxt;
    r_r       <= r_nxt;
    a_r       <= a_nxt;
    tsz_r     <= tsz_nxt;
    granted_r <= granted_nxt;
    split_r   <= split_nxt;
    merges_r  <= merges_nxt;
    status_r  <= status_nxt;
    out_r     <= out_nxt;
  end

endmodule

### src/sfla_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module sfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### test/segregated_free_list_allocator_tb.sv
// Testbench for segregated_free_list_allocator: directed and random allocate/free traffic.
// A scoreboard class predicts each result from its own heap model; depends on sfla_pkg.
`timescale 1ns / 1ps
module segregated_free_list_allocator_tb
  import sfla_pkg::*;
();

  localparam int LIMIT_CYCLES = 900000;
  localparam int NONE = -1;

  class heap_scoreboard;
    int hsize [GRANULES];
    int hprev [GRANULES];
    bit hstat [GRANULES];
    bit hmark [GRANULES];
    int fnext [GRANULES];
    int fprev [GRANULES];
    int heads [CLASS_COUNT];
    int live_n;
    int live_b;
    out_t pending[$];
    int errors;
    int live_offs[$];

    function int class_for(int sz);
      if (sz <= 8) return 0;
      if (sz <= 16) return 1;
      if (sz <= 32) return 2;
      if (sz <= 64) return 3;
      if (sz <= 128) return 4;
      if (sz <= 256) return 5;
      if (sz <= 512) return 6;
      return 7;
    endfunction

    function bit marked(int g);
      return g >= 0 && g < GRANULES && hmark[g];
    endfunction

    function int next_phys(int g);
      return g + ((HEADER_BYTES + hsize[g]) >> 3);
    endfunction

    function void push_free(int g);
      int c;
      int h;
      c = class_for(hsize[g]);
      h = heads[c];
      fprev[g] = NONE;
      fnext[g] = h;
      if (h >= 0 && h < GRANULES) fprev[h] = g;
      heads[c] = g;
    endfunction

    function void unlink_free(int g);
      int p;
      int n;
      p = fprev[g];
      n = fnext[g];
      if (p >= 0 && p < GRANULES) fnext[p] = n;
      else heads[class_for(hsize[g])] = n;
      if (n >= 0 && n < GRANULES) fprev[n] = p;
    endfunction

    function void fix_follower(int g);
      int a;
      a = next_phys(g);
      if (marked(a)) hprev[a] = g;
    endfunction

    function int fit_search(int sz);
      int c;
      int b;
      int guard;
      c = class_for(sz);
      b = heads[c];
      guard = 0;
      while (b >= 0 && b < GRANULES && guard < GRANULES) begin
        if (hsize[b] >= sz) return b;
        b = fnext[b];
        guard++;
      end
      for (int k = c + 1; k < CLASS_COUNT; k++)
        if (heads[k] >= 0 && heads[k] < GRANULES) return heads[k];
      return NONE;
    endfunction

    function void clear();
      foreach (hsize[i]) begin
        hsize[i] = 0; hprev[i] = 0; hstat[i] = 0; hmark[i] = 0;
        fnext[i] = 0; fprev[i] = 0;
      end
      foreach (heads[i]) heads[i] = NONE;
      live_n = 0;
      live_b = 0;
      errors = 0;
      hsize[0] = HEAP_BYTES - HEADER_BYTES;
      hprev[0] = NONE;
      hmark[0] = 1;
      push_free(0);
    endfunction

    function void note_request(in_t req);
      out_t r;
      int sz;
      int g;
      int n;
      int p;
      int off;
      int rg;
      r = '0;
      r.result_status = ST_OK;
      if (req.command == CMD_ALLOC) begin
        sz = req.request_bytes;
        if (sz == 0) r.result_status = ST_ZERO;
        else begin
          sz = (sz + 7) & ~7;
          g = fit_search(sz);
          if (g < 0) r.result_status = ST_OOM;
          else begin
            unlink_free(g);
            if (hsize[g] >= sz + HEADER_BYTES + 8) begin
              rg = g + ((HEADER_BYTES + sz) >> 3);
              hmark[rg] = 1;
              hstat[rg] = 0;
              hsize[rg] = hsize[g] - sz - HEADER_BYTES;
              hprev[rg] = g;
              fix_follower(rg);
              hsize[g] = sz;
              push_free(rg);
              r.residual_split = 1'b1;
            end
            hstat[g] = 1;
            live_n++;
            live_b += hsize[g];
            r.payload_offset = 14'(g * 8 + HEADER_BYTES);
            r.granted_bytes = 14'(hsize[g]);
            live_offs.push_back(g * 8 + HEADER_BYTES);
          end
        end
      end else begin
        off = req.free_offset;
        if (off < HEADER_BYTES || ((off - HEADER_BYTES) & 7) != 0 ||
            !marked((off - HEADER_BYTES) >> 3)) begin
          r.result_status = ST_BAD_PTR;
        end else begin
          g = (off - HEADER_BYTES) >> 3;
          if (hstat[g] != 1) r.result_status = ST_NOT_ALLOC;
          else begin
            hstat[g] = 0;
            live_n--;
            live_b -= hsize[g];
            n = next_phys(g);
            if (marked(n) && hstat[n] == 0) begin
              unlink_free(n);
              hsize[g] += HEADER_BYTES + hsize[n];
              hmark[n] = 0;
              fix_follower(g);
              r.merge_count++;
            end
            p = hprev[g];
            if (marked(p) && hstat[p] == 0) begin
              unlink_free(p);
              hsize[p] += HEADER_BYTES + hsize[g];
              hmark[g] = 0;
              fix_follower(p);
              g = p;
              r.merge_count++;
            end
            push_free(g);
          end
        end
      end
      r.live_blocks = 11'(live_n);
      r.used_bytes = 15'(live_b + HEADER_BYTES * live_n);
      pending.push_back(r);
    endfunction

    function void report(string field, logic [15:0] exp_v, logic [15:0] act_v);
      $display("%0t: %s expected %0d actual %0d", $time, field, exp_v, act_v);
      errors++;
    endfunction

    function void check_result(out_t got);
      out_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.result_status !== e.result_status)
        report("result_status", e.result_status, got.result_status);
      if (got.payload_offset !== e.payload_offset)
        report("payload_offset", e.payload_offset, got.payload_offset);
      if (got.granted_bytes !== e.granted_bytes)
        report("granted_bytes", e.granted_bytes, got.granted_bytes);
      if (got.residual_split !== e.residual_split)
        report("residual_split", e.residual_split, got.residual_split);
      if (got.merge_count !== e.merge_count)
        report("merge_count", e.merge_count, got.merge_count);
      if (got.live_blocks !== e.live_blocks)
        report("live_blocks", e.live_blocks, got.live_blocks);
      if (got.used_bytes !== e.used_bytes)
        report("used_bytes", e.used_bytes, got.used_bytes);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  heap_scoreboard heap;
  int cycles = 0;
  bit hold_off;

  segregated_free_list_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function int gap_len();
    if ($urandom_range(0, 99) < 60) return 0;
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send(in_t item);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    heap.note_request(item);
  endtask

  task automatic send_alloc(int bytes);
    in_t t;
    t = '0;
    t.command = CMD_ALLOC;
    t.request_bytes = 16'(bytes);
    t.free_offset = 14'($urandom);
    send(t);
  endtask

  task automatic send_free(int off);
    in_t t;
    t = '0;
    t.command = CMD_FREE;
    t.free_offset = 14'(off);
    t.request_bytes = 16'($urandom);
    send(t);
  endtask

  task automatic free_random_live();
    int k;
    int off;
    k = $urandom_range(0, heap.live_offs.size() - 1);
    off = heap.live_offs[k];
    heap.live_offs.delete(k);
    send_free(off);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) heap.check_result(out_data);
  end

  initial begin : receiver
    int g;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      g = gap_len();
      if (g > 0) begin
        out_stall <= 1'b1;
        repeat (g) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  initial begin : stimulus
    in_valid = 1'b0;
    in_data = '0;
    rst_n = 1'b0;
    hold_off = 1'b0;
    heap = new();
    heap.clear();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_alloc(0);
    send_alloc(1);
    send_alloc(8);
    send_alloc(9);
    send_alloc(16);
    send_alloc(500);
    send_alloc(513);
    send_alloc(65535);
    send_free(0);
    send_free(17);
    send_free(16383);
    send_free(8);
    free_random_live();
    send_free(16);
    send_alloc(8);
    free_random_live();
    free_random_live();
    free_random_live();
    send_alloc(16368);
    send_alloc(1);
    free_random_live();
    free_random_live();

    hold_off = 1'b1;
    for (int i = 0; i < 650; i++) begin
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) send_alloc($urandom_range(0, 9) == 0 ? $urandom_range(1, 4000)
                                                        : $urandom_range(1, 600));
      else if (pick < 50) send_alloc($urandom);
      else if (pick < 85 && heap.live_offs.size() > 0) free_random_live();
      else if (pick < 93) send_free($urandom);
      else send_free(16 + 8 * $urandom_range(0, GRANULES - 3));
    end
    while (heap.live_offs.size() > 0) free_random_live();
    send_alloc(16368);
    in_valid <= 1'b0;

    while (heap.pending.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (heap.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

### files.f
src/sfla_pkg.sv
src/sfla_ram.sv
src/segregated_free_list_allocator.sv
test/segregated_free_list_allocator_tb.sv
